FILE: rtl/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
// Used by ilp_front, ilp_queue, ilp_back and integer_literal_parser_top.
// No dependencies.
package ilp_pkg;

    // Default width of a signed result: the value field is one bit narrower
    localparam int RESULT_BITS_DEF = 32;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // Width of a character digit value (0 to 35)
    localparam int DIGIT_W = 6;

    // Number base selected by the literal prefix
    typedef enum logic [1:0] {
        RAD_DEC = 2'd0,
        RAD_OCT = 2'd1,
        RAD_HEX = 2'd2
    } ilp_radix_t;

    // One classified character, passed from front to back
    typedef struct packed {
        logic                 fold;   // fold digit into the accumulator
        logic                 bad;    // neither decimal digit nor letter
        logic [DIGIT_W-1:0]   digit;  // digit value, 0 to 35
        ilp_radix_t           radix;  // base for this fold
        logic                 last;   // final character of the literal
    } ilp_op_t;

endpackage

FILE: rtl/ilp_front.sv
// Front part: accepts characters, tracks the base prefix and classifies digits.
// Depends on ilp_pkg.
module ilp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic [7:0]      char_code,
    input  logic            last,
    output logic            push,
    output ilp_pkg::ilp_op_t push_op
);
    import ilp_pkg::*;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    ilp_radix_t radix_reg, radix_next;
    logic       accept;
    logic       is_bad;
    logic [7:0] digit_wide;

    assign accept = in_valid && in_ready;

    // Classify the character as a digit value or a bad character
    always_comb
    begin
        is_bad     = 1'b0;
        digit_wide = '0;
        if (char_code >= CH_ZERO && char_code <= CH_NINE)
        begin
            digit_wide = char_code - CH_ZERO;
        end
        else if (char_code >= CH_LO_A && char_code <= CH_LO_Z)
        begin
            digit_wide = char_code - CH_LO_A + LETTER_OFS;
        end
        else if (char_code >= CH_UP_A && char_code <= CH_UP_Z)
        begin
            digit_wide = char_code - CH_UP_A + LETTER_OFS;
        end
        else
        begin
            is_bad = 1'b1;
        end
    end

    // Walk the prefix and build the word for the back part
    always_comb
    begin
        phase_next    = phase_reg;
        radix_next    = radix_reg;
        push_op.fold  = 1'b1;
        push_op.bad   = is_bad;
        push_op.digit = digit_wide[DIGIT_W-1:0];
        push_op.radix = radix_reg;
        push_op.last  = last;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (char_code == CH_ZERO)
                begin
                    radix_next   = RAD_OCT;
                    phase_next   = PH_ZERO;
                    push_op.fold = 1'b0;
                end
                else
                begin
                    radix_next    = RAD_DEC;
                    phase_next    = PH_DIGITS;
                    push_op.radix = RAD_DEC;
                end
            end
            PH_ZERO:
            begin
                phase_next = PH_DIGITS;
                if (char_code == CH_LO_X || char_code == CH_UP_X)
                begin
                    radix_next   = RAD_HEX;
                    push_op.fold = 1'b0;
                end
                else
                begin
                    radix_next    = RAD_OCT;
                    push_op.radix = RAD_OCT;
                end
            end
            default:
            begin
                push_op.radix = radix_reg;
            end
        endcase
        // Return to the start of a literal after its final character
        if (last)
        begin
            phase_next = PH_FIRST;
            radix_next = RAD_DEC;
        end
    end

    assign push = accept;

    // Hold prefix state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            radix_reg <= RAD_DEC;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
        end
    end

endmodule

FILE: rtl/ilp_queue.sv
// Short queue of classified characters between the front and back parts.
// Depends on ilp_pkg.
module ilp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ilp_pkg::ilp_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output ilp_pkg::ilp_op_t head_op
);
    import ilp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ilp_op_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> full)
        else $error("queue lost an entry while full");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(1)) && do_pop && !do_push |=> !head_valid)
        else $error("queue not empty after draining last entry");

endmodule

FILE: rtl/ilp_back.sv
// Back part: folds digits into the accumulator, flags bad characters and overflow, holds the result.
// Depends on ilp_pkg.
module ilp_back #(
    parameter int RESULT_BITS = ilp_pkg::RESULT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  ilp_pkg::ilp_op_t        head_op,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [RESULT_BITS-2:0]  out_value,
    output logic                    out_ok
);
    import ilp_pkg::*;

    localparam int VW    = RESULT_BITS - 1;
    localparam int PW    = VW + 4;
    localparam int SW    = PW + 1;
    localparam logic [SW-1:0] LIMIT = {{(SW - VW){1'b0}}, {VW{1'b1}}};

    logic [VW-1:0] acc_reg, acc_next;
    logic          failed_reg, failed_next;
    logic          out_valid_reg;
    logic [VW-1:0] out_value_reg;
    logic          out_ok_reg;
    logic [PW-1:0] acc_wide;
    logic [PW-1:0] scaled;
    logic [SW-1:0] sum;

    // Take a word unless it is a final character and the result slot is stuck
    assign pop = head_valid && (!head_op.last || !out_valid_reg || out_ready);

    // Scale by the base as a shift-add
    assign acc_wide = PW'(acc_reg);
    always_comb
    begin
        unique case (head_op.radix)
            RAD_HEX: scaled = acc_wide << 4;
            RAD_OCT: scaled = acc_wide << 3;
            default: scaled = (acc_wide << 3) + (acc_wide << 1);
        endcase
    end

    assign sum = SW'(scaled) + SW'(head_op.digit);

    // Fold the digit, or set the sticky error
    always_comb
    begin
        acc_next    = acc_reg;
        failed_next = failed_reg;
        if (head_op.fold && !failed_reg)
        begin
            if (head_op.bad || sum > LIMIT)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                acc_next = sum[VW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head_op.last)
                begin
                    acc_reg    <= '0;
                    failed_reg <= 1'b0;
                end
                else
                begin
                    acc_reg    <= acc_next;
                    failed_reg <= failed_next;
                end
            end
            // Load the result slot on a final character, drop it once taken
            if (pop && head_op.last)
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= failed_next ? '0 : acc_next;
                out_ok_reg    <= !failed_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_ok    = out_ok_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |-> out_value_reg == '0)
        else $error("failed result carries a non-zero value");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_op.last |=> acc_reg == '0 && !failed_reg)
        else $error("accumulator not cleared after final character");

    a_sticky_fail: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg && !(pop && head_op.last) |=> failed_reg)
        else $error("error flag dropped inside a literal");

endmodule

FILE: rtl/integer_literal_parser_top.sv
// Integer literal parser: one character per cycle in while the queue is not full, one result per literal out.
// A final character is held in the queue, then folded by ilp_back into the result register.
// Throughput: one character per cycle while the queue is not full, set by the shift-add fold in ilp_back.
// A two-word queue parts the front from the back; the result register parts the output.
// Reset (rst_n low, asynchronous) empties the queue and result slot and starts a new literal.
// Depends on ilp_pkg, ilp_front, ilp_queue and ilp_back.
module integer_literal_parser_top #(
    parameter int RESULT_BITS = ilp_pkg::RESULT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] char_code
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [((RESULT_BITS + 6) / 8) * 8 - 1:0] m_axis_tdata,  // value, zero padded
    output logic [0:0]          m_axis_tuser    // [0] ok
);
    import ilp_pkg::*;

    localparam int TDATA_W = ((RESULT_BITS + 6) / 8) * 8;

    logic                   push;
    ilp_op_t                push_op;
    logic                   full;
    logic                   pop;
    logic                   head_valid;
    ilp_op_t                head_op;
    logic [RESULT_BITS-2:0] value;
    logic                   ok;

    assign s_axis_tready = !full;

    ilp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .char_code (s_axis_tdata),
        .last      (s_axis_tlast),
        .push      (push),
        .push_op   (push_op)
    );

    ilp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    ilp_back #(
        .RESULT_BITS (RESULT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (value),
        .out_ok     (ok)
    );

    // Pack the result word
    assign m_axis_tdata = TDATA_W'(value);
    assign m_axis_tuser = ok;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for integer_literal_parser_top: streams C integer literals in,
// one character per word, and checks every parsed value and ok flag against a local model or the directed rows.
// Depends on ilp_pkg and integer_literal_parser_top.
`timescale 1ns / 100ps

module testbench;

    import ilp_pkg::*;

    localparam int RESULT_BITS = RESULT_BITS_DEF;
    localparam int VALUE_W     = RESULT_BITS - 1;
    localparam int TDATA_W     = ((RESULT_BITS + 6) / 8) * 8;
    localparam longint VALUE_MAX = (64'd1 << VALUE_W) - 1;

    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIRECTED_ROWS = 26;

    // Character codes the parser treats specially
    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_9  = "9";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LZ = "z";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_UZ = "Z";
    localparam logic [7:0] CH_LX = "x";
    localparam logic [7:0] CH_UX = "X";

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } lit_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
    } lit_result_t;

    typedef struct {
        logic [7:0]         code;
        logic               last;
        logic               typed;
        logic [VALUE_W-1:0] value;
        logic               ok;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'd0;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [0:0]         m_axis_tuser;

    // Model state of the literal being parsed
    lit_phase_t         lit_phase = PH_FIRST;
    ilp_radix_t         lit_radix = RAD_DEC;
    logic [VALUE_W-1:0] lit_acc = '0;
    logic               lit_failed = 1'b0;

    lit_result_t        expected_literals[$];
    logic [7:0]         lit_chars[$];
    int                 mismatch_count = 0;
    int                 send_calm = 0;
    int                 ready_hold = 0;

    // Directed literals: bare prefixes, letter digits, a bad code, largest value, overflow
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{"0",   1'b1, 1'b1, 31'd0,          1'b1},
        '{"0",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"X",   1'b1, 1'b1, 31'd0,          1'b1},
        '{"0",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"Z",   1'b1, 1'b1, 31'd35,         1'b1},
        '{8'hFF, 1'b1, 1'b1, 31'd0,          1'b0},
        '{"0",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"x",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"7",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"f",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"f",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"F",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"f",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"F",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"f",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"f",   1'b1, 1'b1, 31'd2147483647, 1'b1},
        '{"0",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"x",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"z",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"z",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"z",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"z",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"z",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"z",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"z",   1'b0, 1'b0, 31'd0,          1'b0},
        '{"z",   1'b1, 1'b1, 31'd0,          1'b0}
    };

    integer_literal_parser_top #(
        .RESULT_BITS(RESULT_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Append one expected result to the back of the queue
    function automatic void queue_result(input lit_result_t r);
        expected_literals = {expected_literals, r};
    endfunction

    // Append one character to the literal being built
    function automatic void add_char(input logic [7:0] c);
        lit_chars = {lit_chars, c};
    endfunction

    // Digit value of a character, -1 for anything that is neither digit nor letter
    function automatic int digit_of(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LZ)
            return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UZ)
            return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // Fold one character into the accumulator; latch the error on a bad code or overflow
    function automatic void fold_digit(input logic [7:0] c);
        longint base;
        int     d;
        base = (lit_radix == RAD_HEX) ? 16 : (lit_radix == RAD_OCT) ? 8 : 10;
        d = digit_of(c);
        if (lit_failed)
            return;
        if (d < 0)
        begin
            lit_failed = 1'b1;
            return;
        end
        if (longint'(lit_acc) > (VALUE_MAX - d) / base)
        begin
            lit_failed = 1'b1;
            return;
        end
        lit_acc = VALUE_W'(longint'(lit_acc) * base + d);
    endfunction

    // Advance the literal model by one character; give the result on the final one
    function automatic void parse_char(input logic [7:0] c, input logic last,
                                       output logic got, output lit_result_t res);
        case (lit_phase)
            PH_FIRST:
            begin
                if (c == CH_0)
                begin
                    lit_radix = RAD_OCT;
                    lit_phase = PH_ZERO;
                end
                else
                begin
                    lit_radix = RAD_DEC;
                    lit_phase = PH_DIGITS;
                    fold_digit(c);
                end
            end
            PH_ZERO:
            begin
                lit_phase = PH_DIGITS;
                if (c == CH_LX || c == CH_UX)
                    lit_radix = RAD_HEX;
                else
                begin
                    lit_radix = RAD_OCT;
                    fold_digit(c);
                end
            end
            default:
                fold_digit(c);
        endcase
        got = last;
        res.value = lit_failed ? '0 : lit_acc;
        res.ok = !lit_failed;
        if (last)
        begin
            lit_phase = PH_FIRST;
            lit_radix = RAD_DEC;
            lit_acc = '0;
            lit_failed = 1'b0;
        end
    endfunction

    // Sender gap: mostly none or short, a few long, with calm stretches of no gaps
    function automatic int pick_gap();
        int r;
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            send_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Digit count after the prefix: mostly short, some long enough to overflow
    function automatic int pick_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 4);
        return $urandom_range(5, 12);
    endfunction

    // Fill lit_chars with one literal: mostly well formed, the rest letters and noise
    function automatic void build_literal();
        int kind;
        int n;
        lit_chars.delete();
        kind = $urandom_range(0, 99);
        n = pick_len();
        if (kind < 40)
        begin
            add_char(pick_from("123456789"));
            repeat (n) add_char(pick_from("0123456789"));
        end
        else if (kind < 60)
        begin
            add_char(CH_0);
            add_char($urandom_range(0, 1) ? CH_LX : CH_UX);
            repeat (n) add_char(pick_from("0123456789abcdefABCDEF"));
        end
        else if (kind < 75)
        begin
            add_char(CH_0);
            repeat (n) add_char(pick_from("01234567"));
        end
        else if (kind < 88)
        begin
            repeat (n + 1)
                add_char(pick_from(
                    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        end
        else
        begin
            repeat (n + 1)
                add_char($urandom_range(0, 1) ? pick_from("0xX9aZ7")
                                              : 8'($urandom_range(0, 255)));
        end
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Receiver back-pressure: short toggles, occasional long stalls and long open runs
    always @(posedge clk)
    begin
        int r;
        if (ready_hold > 0)
            ready_hold--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(0, 3);
            end
            else if (r < 85)
            begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end
            else if (r < 95)
            begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(20, 80);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(5, 30);
            end
        end
    end

    // Check each accepted result word against the oldest expected literal
    always @(posedge clk)
    begin : result_check
        lit_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_literals.size() == 0)
            begin
                $display("%0t: unexpected result: value %0d ok %0d", $time,
                         m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = expected_literals.pop_front();
                if (m_axis_tdata !== TDATA_W'(want.value))
                begin
                    $display("%0t: value mismatch: expected %0d actual %0d", $time,
                             want.value, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.ok)
                begin
                    $display("%0t: ok mismatch: expected %0d actual %0d", $time,
                             want.ok, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: give up well beyond the slowest correct run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        int          sent;
        logic        got;
        lit_result_t res;

        // Hold reset low, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; typed rows carry their own expectation
        foreach (directed_rows[i])
        begin
            send_char(directed_rows[i].code, directed_rows[i].last);
            parse_char(directed_rows[i].code, directed_rows[i].last, got, res);
            if (directed_rows[i].typed)
                queue_result({directed_rows[i].value, directed_rows[i].ok});
            else if (got)
                queue_result(res);
        end

        // Random literals, each ending on a word with tlast set
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            build_literal();
            foreach (lit_chars[i])
            begin
                send_char(lit_chars[i], i == lit_chars.size() - 1);
                parse_char(lit_chars[i], i == lit_chars.size() - 1, got, res);
                if (got)
                    queue_result(res);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then allow for the output latency
        while (expected_literals.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
